[rtl/drs_pkg.sv]
// shared types, constants and helper functions of the disk request scheduler
package drs_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TRACK_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    POL_FIFO  = 3'd0,
    POL_SSTF  = 3'd1,
    POL_SCAN  = 3'd2,
    POL_CSCAN = 3'd3,
    POL_FSCAN = 3'd4
  } policy_e;

  typedef enum logic [1:0] {
    STS_ACCEPTED = 2'd0,
    STS_FULL     = 2'd1,
    STS_SERVED   = 2'd2,
    STS_NONE     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    SIDE_ANY,
    SIDE_ABOVE,
    SIDE_BELOW
  } side_e;

  typedef logic [TRACK_BITS-1:0] track_t;

  typedef struct packed {
    logic                valid;
    logic                grp;
    track_t              track;
    logic [FIELD_W-1:0]  tag;
  } entry_t;

  // search context, fixed for the whole pass
  typedef struct packed {
    track_t head;
    side_e  pri_side;
    logic   pri_fifo;
    logic   fb_en;
    side_e  fb_side;
    logic   fb_by_track;
    logic   use_grp;
    logic   grp;
  } ctx_t;

  typedef struct packed {
    logic                ok;
    track_t              key;
    track_t              track;
    logic [FIELD_W-1:0]  tag;
    logic                grp;
    logic [IDX_W-1:0]    idx;
  } cand_t;

  typedef struct packed {
    cand_t pri;
    cand_t fb;
  } tok_t;

  function automatic logic side_ok(side_e side, track_t t, track_t h);
    logic r;
    case (side)
      SIDE_ABOVE: r = (t >= h);
      SIDE_BELOW: r = (t <= h);
      default:    r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic track_t abs_diff(track_t a, track_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic ctx_t mk_ctx(logic [2:0] pol, track_t head, logic dir, logic grp);
    ctx_t c;
    c.head        = head;
    c.pri_side    = SIDE_ANY;
    c.pri_fifo    = 1'b0;
    c.fb_en       = 1'b0;
    c.fb_side     = SIDE_ANY;
    c.fb_by_track = 1'b0;
    c.use_grp     = 1'b0;
    c.grp         = grp;
    case (pol)
      POL_SSTF: begin
        c.pri_side = SIDE_ANY;
      end
      POL_SCAN, POL_FSCAN: begin
        c.pri_side = dir ? SIDE_ABOVE : SIDE_BELOW;
        c.fb_en    = 1'b1;
        c.fb_side  = dir ? SIDE_BELOW : SIDE_ABOVE;
        c.use_grp  = (pol == POL_FSCAN);
      end
      POL_CSCAN: begin
        c.pri_side    = SIDE_ABOVE;
        c.fb_en       = 1'b1;
        c.fb_side     = SIDE_ANY;
        c.fb_by_track = 1'b1;
      end
      default: begin
        c.pri_fifo = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/drs_if.sv]
// handshake channels of the disk request scheduler
interface drs_req_if;
  import drs_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [FIELD_W-1:0] request_track;
  logic [FIELD_W-1:0] request_tag;
  modport source (output valid, action, request_track, request_tag, input ready);
  modport sink   (input valid, action, request_track, request_tag, output ready);
endinterface

interface drs_rsp_if;
  import drs_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FIELD_W-1:0] served_track;
  logic [FIELD_W-1:0] served_tag;
  logic [FIELD_W-1:0] seek_distance;
  logic               head_upward;
  modport source (output valid, status, served_track, served_tag, seek_distance,
                  head_upward, input ready);
  modport sink   (input valid, status, served_track, served_tag, seek_distance,
                  head_upward, output ready);
endinterface

interface drs_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] policy;
  modport source (output valid, policy, input ready);
  modport sink   (input valid, policy, output ready);
endinterface

[rtl/drs_cell.sv]
// one slot of the request chain with its stage of the search pass
module drs_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [drs_pkg::IDX_W-1:0] cell_idx_i,
  input  drs_pkg::ctx_t         ctx_i,
  input  drs_pkg::tok_t         tok_i,
  input  logic                  wr_en_i,
  input  drs_pkg::entry_t       wr_entry_i,
  input  logic                  shift_en_i,
  input  drs_pkg::entry_t       nb_i,
  output drs_pkg::entry_t       entry_o,
  output drs_pkg::tok_t         tok_o
);
  import drs_pkg::*;

  logic                valid_q;
  logic                grp_q;
  track_t              track_q;
  logic [FIELD_W-1:0]  tag_q;
  tok_t                tok_q, tok_d;

  // slot storage: enqueue write or shift down from the next slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en_i) begin
      valid_q <= nb_i.valid;
    end else if (wr_en_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      grp_q   <= nb_i.grp;
      track_q <= nb_i.track;
      tag_q   <= nb_i.tag;
    end else if (wr_en_i) begin
      grp_q   <= wr_entry_i.grp;
      track_q <= wr_entry_i.track;
      tag_q   <= wr_entry_i.tag;
    end
  end

  // compare this slot against the best candidates handed in
  always_comb begin
    logic   elig;
    track_t delta;
    track_t key;
    elig  = valid_q && (!ctx_i.use_grp || (grp_q == ctx_i.grp));
    delta = abs_diff(track_q, ctx_i.head);
    tok_d = tok_i;
    key   = ctx_i.pri_fifo ? '0 : delta;
    if (elig && side_ok(ctx_i.pri_side, track_q, ctx_i.head) &&
        (!tok_i.pri.ok || key < tok_i.pri.key)) begin
      tok_d.pri = '{ok: 1'b1, key: key, track: track_q, tag: tag_q, grp: grp_q,
                    idx: cell_idx_i};
    end
    key = ctx_i.fb_by_track ? track_q : delta;
    if (ctx_i.fb_en && elig && side_ok(ctx_i.fb_side, track_q, ctx_i.head) &&
        (!tok_i.fb.ok || key < tok_i.fb.key)) begin
      tok_d.fb = '{ok: 1'b1, key: key, track: track_q, tag: tag_q, grp: grp_q,
                   idx: cell_idx_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign entry_o = '{valid: valid_q, grp: grp_q, track: track_q, tag: tag_q};
  assign tok_o   = tok_q;

endmodule

[rtl/disk_request_scheduler_core.sv]
// disk request scheduler top level: control, head state and the slot chain
// enqueue: result registered in the cycle after the transfer; select on an empty store likewise
// select: the search token walks the slot chain, then the finish state registers the result once the output is free
// one item at a time; the next input transfer is taken in idle once the result register is free or being read
// reset: store empty, head at track 0 moving up, group 0 active, policy fifo
module disk_request_scheduler_core (
  input logic       clk_i,
  input logic       rst_ni,
  drs_req_if.sink   req,
  drs_rsp_if.source rsp,
  drs_cfg_if.sink   cfg
);
  import drs_pkg::*;

  state_e              state_q, state_d;
  logic [2:0]          policy_q;
  track_t              head_q, head_d;
  logic                dir_q, dir_d;
  logic                act_q, act_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    gcnt0_q, gcnt0_d, gcnt1_q, gcnt1_d;
  ctx_t                ctx_q, ctx_d;
  logic [IDX_W:0]      step_q, step_d;
  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic [FIELD_W-1:0]  otrack_q, otrack_d, otag_q, otag_d, odist_q, odist_d;
  logic                oup_q, oup_d;
  logic                req_ready;
  logic                do_enq, do_rem;
  logic [IDX_W-1:0]    rem_idx;
  entry_t              new_entry;

  entry_t              ent   [QUEUE_DEPTH];
  tok_t                tok   [QUEUE_DEPTH];
  tok_t                tok_init;

  assign tok_init = '0;
  assign new_entry = '{valid: 1'b1, grp: ~act_q,
                       track: TRACK_BITS'(req.request_track), tag: req.request_tag};

  // slot chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nb;
    tok_t   tin;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = ent[i+1];
    end
    if (i == 0) begin : g_first
      assign tin = tok_init;
    end else begin : g_rest
      assign tin = tok[i-1];
    end
    drs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .ctx_i      (ctx_q),
      .tok_i      (tin),
      .wr_en_i    (do_enq && (cnt_q == CNT_W'(i))),
      .wr_entry_i (new_entry),
      .shift_en_i (do_rem && (IDX_W'(i) >= rem_idx)),
      .nb_i       (nb),
      .entry_o    (ent[i]),
      .tok_o      (tok[i])
    );
  end

  // configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIFO;
    end else if (cfg.valid) begin
      policy_q <= cfg.policy;
    end
  end

  // sequencer and head state
  always_comb begin
    logic   acc;
    logic   out_free;
    logic   act_n, dir_n;
    cand_t  sel;
    logic [CNT_W-1:0] g0, g1;
    acc      = 1'b0;
    out_free = !out_valid_q || rsp.ready;
    act_n    = act_q;
    dir_n    = dir_q;
    sel      = tok[QUEUE_DEPTH-1].pri.ok ? tok[QUEUE_DEPTH-1].pri : tok[QUEUE_DEPTH-1].fb;
    g0       = gcnt0_q;
    g1       = gcnt1_q;
    state_d  = state_q;
    head_d   = head_q;
    dir_d    = dir_q;
    act_d    = act_q;
    cnt_d    = cnt_q;
    gcnt0_d  = gcnt0_q;
    gcnt1_d  = gcnt1_q;
    ctx_d    = ctx_q;
    step_d   = step_q;
    out_valid_d = out_valid_q && !rsp.ready;
    status_d = status_q;
    otrack_d = otrack_q;
    otag_d   = otag_q;
    odist_d  = odist_q;
    oup_d    = oup_q;
    do_enq   = 1'b0;
    do_rem   = 1'b0;
    rem_idx  = sel.idx;
    req_ready = (state_q == ST_IDLE) && out_free;
    acc      = req.valid && req_ready;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          otrack_d = '0;
          otag_d   = '0;
          odist_d  = '0;
          oup_d    = dir_q;
          if (!req.action) begin
            out_valid_d = 1'b1;
            if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
              status_d = STS_FULL;
            end else begin
              status_d = STS_ACCEPTED;
              do_enq   = 1'b1;
              cnt_d    = cnt_q + 1'b1;
              if (act_q) gcnt0_d = gcnt0_q + 1'b1;
              else       gcnt1_d = gcnt1_q + 1'b1;
            end
          end else if (cnt_q == '0) begin
            out_valid_d = 1'b1;
            status_d    = STS_NONE;
          end else begin
            // f-scan swaps groups first when the served group is empty
            if (policy_q == POL_FSCAN && (act_q ? gcnt1_q : gcnt0_q) == '0 &&
                (act_q ? gcnt0_q : gcnt1_q) != '0) begin
              act_n = ~act_q;
              dir_n = 1'b1;
            end
            act_d   = act_n;
            dir_d   = dir_n;
            ctx_d   = mk_ctx(policy_q, head_q, dir_n, act_n);
            step_d  = '0;
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        step_d = step_q + 1'b1;
        if (step_q == (IDX_W+1)'(QUEUE_DEPTH - 1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          do_rem = 1'b1;
          case (policy_q)
            POL_SCAN, POL_FSCAN: if (!tok[QUEUE_DEPTH-1].pri.ok) dir_n = ~dir_q;
            POL_CSCAN:           if (tok[QUEUE_DEPTH-1].pri.ok) dir_n = 1'b1;
            default:             dir_n = dir_q;
          endcase
          cnt_d = cnt_q - 1'b1;
          if (sel.grp) g1 = gcnt1_q - 1'b1;
          else         g0 = gcnt0_q - 1'b1;
          gcnt0_d = g0;
          gcnt1_d = g1;
          if (policy_q == POL_FSCAN && (act_q ? g1 : g0) == '0) begin
            act_d = ~act_q;
            dir_n = 1'b1;
          end
          dir_d       = dir_n;
          head_d      = sel.track;
          out_valid_d = 1'b1;
          status_d    = STS_SERVED;
          otrack_d    = FIELD_W'(sel.track);
          otag_d      = sel.tag;
          odist_d     = FIELD_W'(abs_diff(sel.track, head_q));
          oup_d       = dir_n;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      dir_q       <= 1'b1;
      act_q       <= 1'b0;
      cnt_q       <= '0;
      gcnt0_q     <= '0;
      gcnt1_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      dir_q       <= dir_d;
      act_q       <= act_d;
      cnt_q       <= cnt_d;
      gcnt0_q     <= gcnt0_d;
      gcnt1_q     <= gcnt1_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload and search context
  always_ff @(posedge clk_i) begin
    ctx_q    <= ctx_d;
    status_q <= status_d;
    otrack_q <= otrack_d;
    otag_q   <= otag_d;
    odist_q  <= odist_d;
    oup_q    <= oup_d;
  end

  assign req.ready         = req_ready;
  assign rsp.valid         = out_valid_q;
  assign rsp.status        = status_q;
  assign rsp.served_track  = otrack_q;
  assign rsp.served_tag    = otag_q;
  assign rsp.seek_distance = odist_q;
  assign rsp.head_upward   = oup_q;

endmodule

[sim/disk_request_scheduler_core_test.sv]
// self-checking testbench of the disk request scheduler core
module disk_request_scheduler_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import drs_pkg::*;

  localparam int NUM_RANDOM = 400;
  localparam longint CYCLE_LIMIT = 400000;

  // one expected or observed result
  typedef struct {
    status_e            status;
    logic [FIELD_W-1:0] track;
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] seek;
    logic               upward;
  } serve_rsp_t;

  // queue model and store of expected results
  class sched_scoreboard;
    logic [2:0]         policy;
    logic [FIELD_W-1:0] slot_track[$];
    logic [FIELD_W-1:0] slot_tag[$];
    logic               slot_grp[$];
    logic [FIELD_W-1:0] head;
    logic               dir;
    logic               active;
    serve_rsp_t         pending_rsp[$];
    int                 mismatches;

    function new();
      policy = POL_FIFO;
      head = '0;
      dir = 1'b1;
      active = 1'b0;
      mismatches = 0;
    endfunction

    function int group_size(logic g);
      int n;
      n = 0;
      foreach (slot_grp[i]) if (slot_grp[i] == g) n++;
      return n;
    endfunction

    // nearest (or lowest) candidate on a side, earliest arrival on ties
    function int nearest(side_e side, bit by_track, bit use_grp, logic g);
      int best;
      logic [FIELD_W-1:0] best_key, key, t;
      best = -1;
      best_key = '0;
      foreach (slot_track[i]) begin
        t = slot_track[i];
        if (use_grp && slot_grp[i] != g) continue;
        if (side == SIDE_ABOVE && t < head) continue;
        if (side == SIDE_BELOW && t > head) continue;
        key = by_track ? t : ((t >= head) ? t - head : head - t);
        if (best < 0 || key < best_key) begin
          best = i;
          best_key = key;
        end
      end
      return best;
    endfunction

    function int sweep(bit use_grp, logic g);
      int i;
      i = nearest(dir ? SIDE_ABOVE : SIDE_BELOW, 0, use_grp, g);
      if (i >= 0) return i;
      i = nearest(dir ? SIDE_BELOW : SIDE_ABOVE, 0, use_grp, g);
      if (i >= 0) dir = ~dir;
      return i;
    endfunction

    // note an accepted input transfer and predict its result
    function void note_request(logic act, logic [FIELD_W-1:0] trk, logic [FIELD_W-1:0] tg);
      serve_rsp_t r;
      int idx;
      r.track = '0;
      r.tag = '0;
      r.seek = '0;
      if (!act) begin
        if (slot_track.size() >= QUEUE_DEPTH) r.status = STS_FULL;
        else begin
          slot_track.push_back(trk);
          slot_tag.push_back(tg);
          slot_grp.push_back(~active);
          r.status = STS_ACCEPTED;
        end
      end else begin
        if (policy == POL_FSCAN && group_size(active) == 0 && group_size(~active) > 0) begin
          active = ~active;
          dir = 1'b1;
        end
        case (policy)
          POL_SSTF:  idx = nearest(SIDE_ANY, 0, 0, 0);
          POL_SCAN:  idx = sweep(0, 0);
          POL_CSCAN: begin
            idx = nearest(SIDE_ABOVE, 0, 0, 0);
            if (idx >= 0) dir = 1'b1;
            else idx = nearest(SIDE_ANY, 1, 0, 0);
          end
          POL_FSCAN: idx = sweep(1, active);
          default:   idx = (slot_track.size() > 0) ? 0 : -1;
        endcase
        if (idx < 0) r.status = STS_NONE;
        else begin
          r.status = STS_SERVED;
          r.track = slot_track[idx];
          r.tag = slot_tag[idx];
          r.seek = (r.track >= head) ? r.track - head : head - r.track;
          head = r.track;
          slot_track.delete(idx);
          slot_tag.delete(idx);
          slot_grp.delete(idx);
          if (policy == POL_FSCAN && group_size(active) == 0) begin
            active = ~active;
            dir = 1'b1;
          end
        end
      end
      r.upward = dir;
      pending_rsp.push_back(r);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(serve_rsp_t got);
      serve_rsp_t exp_r;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", got.status);
        return;
      end
      exp_r = pending_rsp.pop_front();
      if (got.status != exp_r.status || got.track != exp_r.track || got.tag != exp_r.tag ||
          got.seek != exp_r.seek || got.upward != exp_r.upward) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp sts %0d trk %0d tag %0d seek %0d up %0d, got %0d %0d %0d %0d %0d",
                   exp_r.status, exp_r.track, exp_r.tag, exp_r.seek, exp_r.upward,
                   got.status, got.track, got.tag, got.seek, got.upward);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  drs_req_if req ();
  drs_rsp_if rsp ();
  drs_cfg_if cfg ();

  sched_scoreboard board;
  bit  sender_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;
  bit  long_hold = 1'b0;
  longint cycle_count = 0;

  disk_request_scheduler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .rsp    (rsp.source),
    .cfg    (cfg.sink)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0;
    req.action = 1'b0;
    req.request_track = '0;
    req.request_tag = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.policy = '0;
    board = new();
  end

  // timeout guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[disk_request_scheduler_core] ERROR");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    int k;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        rsp.ready <= 1'b0;
        for (k = 0; k < 600; k++) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    serve_rsp_t got;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got.status = status_e'(rsp.status);
      got.track = rsp.served_track;
      got.tag = rsp.served_tag;
      got.seek = rsp.seek_distance;
      got.upward = rsp.head_upward;
      board.check_result(got);
    end
  end

  // drive one request transfer, with optional idling ahead of it
  task automatic send_request(logic act, logic [FIELD_W-1:0] trk, logic [FIELD_W-1:0] tg);
    int gap;
    if (sender_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.request_track <= trk;
    req.request_tag <= tg;
    do @(posedge clk_i); while (!req.ready);
    board.note_request(act, trk, tg);
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
  endtask

  // set the policy register while the block is idle
  task automatic write_policy(logic [2:0] pol);
    cfg.valid <= 1'b1;
    cfg.policy <= pol;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    board.policy = pol;
  endtask

  // random track biased to clusters and the ends
  function automatic logic [FIELD_W-1:0] pick_track();
    case ($urandom_range(0, 3))
      0: return FIELD_W'($urandom_range(0, 15));
      1: return FIELD_W'(32'hFFFF - $urandom_range(0, 15));
      2: return FIELD_W'($urandom_range(100, 140));
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  initial begin
    int i, p, n;
    logic [2:0] pols[8];
    pols = '{POL_FIFO, POL_SSTF, POL_SCAN, POL_CSCAN, POL_FSCAN,
             3'd7, POL_FSCAN, POL_SCAN};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty select, field extremes, fill to full, drop, drain
    send_request(1'b1, '0, '0);
    send_request(1'b0, 16'hFFFF, 16'hFFFF);
    send_request(1'b0, 16'h0000, 16'h0000);
    send_request(1'b0, 16'h5555, 16'hAAAA);
    send_request(1'b1, '0, '0);
    drain_results();
    write_policy(POL_FIFO);
    long_hold = 1'b1;
    for (i = 0; i < QUEUE_DEPTH; i++) send_request(1'b0, pick_track(), FIELD_W'($urandom()));
    drain_results();
    for (i = 0; i < 4; i++) send_request(1'b1, FIELD_W'($urandom()), FIELD_W'($urandom()));
    drain_results();

    // policy phases; each ends by emptying the store
    for (p = 0; p < 8; p++) begin
      write_policy(pols[p]);
      if (p == 7) begin
        sender_idle_on = 1'b0;
        sink_idle_on = 1'b0;
      end
      n = 0;
      while (n < NUM_RANDOM / 8) begin
        if ($urandom_range(0, 99) < 55)
          send_request(1'b0, pick_track(), FIELD_W'($urandom()));
        else send_request(1'b1, FIELD_W'($urandom()), FIELD_W'($urandom()));
        n++;
      end
      while (board.slot_track.size() != 0)
        send_request(1'b1, FIELD_W'($urandom()), FIELD_W'($urandom()));
      drain_results();
    end
    write_policy(POL_FIFO);

    drain_results();
    if (board.mismatches == 0 && board.pending_rsp.size() == 0) begin
      $display("[disk_request_scheduler_core] OK");
    end else begin
      $display("[disk_request_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/drs_pkg.sv
rtl/drs_if.sv
rtl/drs_cell.sv
rtl/disk_request_scheduler_core.sv
sim/disk_request_scheduler_core_test.sv
